[rtl/vabs_pkg.sv]
`default_nettype none
package vabs_pkg;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 24;
   localparam int VIEW_WIDTH     = 16;
   localparam int COUNT_WIDTH    = 13;
   localparam int INDEX_WIDTH    = 14;
   localparam int TEX_WIDTH      = 16;
   localparam int DIVISOR_WIDTH  = 24;

   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_EXTENT_X    = 3'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_EXTENT_Y    = 3'd1;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_EXTENT_Z    = 3'd2;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_VIEW_X      = 3'd3;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_VIEW_Y      = 3'd4;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_VIEW_Z      = 3'd5;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_SLICE_COUNT = 3'd6;

   typedef enum logic [4:0] {
      ST_IDLE, ST_PROD, ST_DEPTH, ST_RANK, ST_STAGE, ST_OFFMUL, ST_OFFDIV, ST_OFFWAIT,
      ST_CHECK, ST_PIVOT, ST_EDGE, ST_POS, ST_POSWAIT, ST_TEX, ST_TEXWAIT, ST_LOAD, ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      DIV_OFF, DIV_POS, DIV_TEX
   } div_sel_type;

   typedef struct packed {
      logic        accept;
      logic        prod_en;
      logic        depth_en;
      logic        rank_en;
      logic        stage_en;
      logic        off_mul_en;
      logic        div_start;
      div_sel_type div_sel;
      logic        off_en;
      logic        check_en;
      logic        pivot_en;
      logic        edge_en;
      logic        pos_en;
      logic        tex_en;
      logic        out_load;
      logic        out_beyond;
      logic        out_last;
      logic [1:0]  axis;
      logic [2:0]  stage_idx;
      logic [2:0]  edge_idx;
   } cmd_type;

   typedef struct packed {
      logic       div_done;
      logic       beyond;
      logic       need_interp;
      logic       ext_zero;
      logic [2:0] edge_count;
   } status_type;

   // corner k sits at the far face of axis ax
   function automatic logic corner_on(input logic [2:0] k, input logic [1:0] ax);
      logic r;
      case (ax)
         2'd0:    r = k[0] ^ k[1];
         2'd1:    r = k[1];
         default: r = k[2];
      endcase
      return r;
   endfunction

   // three neighbours of each corner, in winding order
   function automatic logic [8:0] ring_of(input logic [2:0] k);
      logic [8:0] r;
      case (k)
         3'd0:    r = {3'd3, 3'd4, 3'd1};
         3'd1:    r = {3'd0, 3'd5, 3'd2};
         3'd2:    r = {3'd1, 3'd6, 3'd3};
         3'd3:    r = {3'd2, 3'd7, 3'd0};
         3'd4:    r = {3'd5, 3'd0, 3'd7};
         3'd5:    r = {3'd6, 3'd1, 3'd4};
         3'd6:    r = {3'd7, 3'd2, 3'd5};
         default: r = {3'd4, 3'd3, 3'd6};
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

[rtl/vabs_divider.sv]
`default_nettype none
module vabs_divider #(
   parameter int DVW = 43,
   parameter int DSW = 24
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic [DVW-1:0] dividend,
   input  wire logic [DSW-1:0] divisor,
   output logic      [DVW-1:0] quotient,
   output logic                done
);
   localparam int CNTW = $clog2(DVW + 1);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic [DSW-1:0]  rem_ff, rem_in;
   logic [DSW-1:0]  div_ff, div_in;
   logic [DVW-1:0]  quo_ff, quo_in;
   logic [DSW:0]    shifted;
   logic            ge;

   always_comb begin
      shifted  = {rem_ff, quo_ff[DVW-1]};
      ge       = shifted >= {1'b0, div_ff};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      quo_in   = quo_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNTW'(DVW);
         rem_in   = '0;
         div_in   = divisor;
         quo_in   = dividend;
      end else if (busy_ff) begin
         rem_in   = ge ? DSW'(shifted - {1'b0, div_ff}) : shifted[DSW-1:0];
         quo_in   = {quo_ff[DVW-2:0], ge};
         count_in = count_ff - CNTW'(1);
         if (count_ff == CNTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;
endmodule
`default_nettype wire

[rtl/vabs_datapath.sv]
`default_nettype none
module vabs_datapath #(
   parameter int COORD_WIDTH = 24
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_we,
   input  wire logic [vabs_pkg::CSR_ADDR_WIDTH-1:0]  csr_addr,
   input  wire logic [vabs_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  wire logic [vabs_pkg::INDEX_WIDTH-1:0]     req_slice_index,
   input  wire vabs_pkg::cmd_type                    cmd,
   output vabs_pkg::status_type                      status,
   output logic [COORD_WIDTH-1:0]                    rsp_pos_x,
   output logic [COORD_WIDTH-1:0]                    rsp_pos_y,
   output logic [COORD_WIDTH-1:0]                    rsp_pos_z,
   output logic [vabs_pkg::TEX_WIDTH-1:0]            rsp_tex_u,
   output logic [vabs_pkg::TEX_WIDTH-1:0]            rsp_tex_v,
   output logic [vabs_pkg::TEX_WIDTH-1:0]            rsp_tex_w,
   output logic                                      rsp_beyond_box,
   output logic                                      rsp_last_vertex
);
   import vabs_pkg::*;

   localparam int EXW  = (COORD_WIDTH < 24) ? COORD_WIDTH : 24;
   localparam int PW   = EXW + 17;
   localparam int DW   = EXW + 19;
   localparam int OW   = EXW + 19;
   localparam int DVW  = (DW > COORD_WIDTH + 16) ? DW : COORD_WIDTH + 16;
   localparam int CMPW = OW + 16;

   logic        [EXW-1:0]         ext_ff [3];
   logic signed [VIEW_WIDTH-1:0]  view_ff [3];
   logic        [COUNT_WIDTH-1:0] cnt_ff;

   logic signed [PW-1:0]          prod_ff [3];
   logic signed [DW-1:0]          cd_ff [8];
   logic signed [DW-1:0]          sd_ff [8];
   logic        [2:0]             sorted_ff [8];
   logic        [5:0][5:0]        rows_ff [7];
   logic        [2:0]             ecnt_ff [7];
   logic        [5:0][5:0]        prev_row_ff;
   logic        [2:0]             prev_cnt_ff;
   logic        [7:0]             used_ff;

   logic        [18:0]            idx23_ff;
   logic        [OW-1:0]          num_ff;
   logic        [OW-1:0]          off_ff;
   logic signed [DW-1:0]          depth_ff;
   logic                          beyond_ff;
   logic        [2:0]             piv_ff;
   logic        [2:0]             edge_a_ff, edge_b_ff;
   logic        [COORD_WIDTH-1:0] pos_ff [3];
   logic        [TEX_WIDTH-1:0]   tex_ff [3];

   logic signed [DW-1:0]          cd_in [8];
   logic        [2:0]             rk [8];

   logic        [2:0]             st_piv, ra, rb, rc, ea, eb, c0, c1, st_n;
   logic        [8:0]             ring;
   logic        [7:0]             st_used;
   logic        [5:0][5:0]        st_row;
   logic                          st_done;

   logic        [DW-1:0]          depth_span;
   logic        [OW+14:0]         off_shift;
   logic                          beyond_in;
   logic        [2:0]             piv_in;

   logic        [5:0]             cur_edge;
   logic        [EXW-1:0]         ext_cur;
   logic signed [VIEW_WIDTH-1:0]  view_cur;
   logic signed [DW-1:0]          da;
   logic                          on_a, on_b;
   logic        [DW-1:0]          diff;
   logic        [VIEW_WIDTH-1:0]  mag;
   logic        [EXW-1:0]         qc;
   logic        [COORD_WIDTH-1:0] pos_val;
   logic        [TEX_WIDTH-1:0]   tex_val;
   logic        [16:0]            den;

   logic        [DVW-1:0]         div_dividend, div_q;
   logic        [DIVISOR_WIDTH-1:0] div_divisor;
   logic                          div_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_ff[0]  <= EXW'(4096);
         ext_ff[1]  <= EXW'(4096);
         ext_ff[2]  <= EXW'(4096);
         view_ff[0] <= '0;
         view_ff[1] <= '0;
         view_ff[2] <= 16'sd32767;
         cnt_ff     <= 13'd256;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_EXTENT_X:    ext_ff[0]  <= csr_wdata[EXW-1:0];
            CSR_EXTENT_Y:    ext_ff[1]  <= csr_wdata[EXW-1:0];
            CSR_EXTENT_Z:    ext_ff[2]  <= csr_wdata[EXW-1:0];
            CSR_VIEW_X:      view_ff[0] <= csr_wdata[VIEW_WIDTH-1:0];
            CSR_VIEW_Y:      view_ff[1] <= csr_wdata[VIEW_WIDTH-1:0];
            CSR_VIEW_Z:      view_ff[2] <= csr_wdata[VIEW_WIDTH-1:0];
            CSR_SLICE_COUNT: cnt_ff     <= csr_wdata[COUNT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // corner depths and stable ranks
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         cd_in[k] = '0;
         for (int ax = 0; ax < 3; ax++) begin
            if (corner_on(3'(k), 2'(ax))) cd_in[k] = cd_in[k] + DW'(prod_ff[ax]);
         end
      end
      for (int i = 0; i < 8; i++) begin
         rk[i] = '0;
         for (int j = 0; j < 8; j++) begin
            if (j != i && (cd_ff[j] < cd_ff[i] || (cd_ff[j] == cd_ff[i] && j < i)))
               rk[i] = rk[i] + 3'd1;
         end
      end
   end

   // one active-edge row per step: the first from the pivot's ring, the rest from the previous row
   always_comb begin
      st_piv  = sorted_ff[cmd.stage_idx];
      ring    = ring_of(st_piv);
      ra      = ring[8:6];
      rb      = ring[5:3];
      rc      = ring[2:0];
      st_used = ((cmd.stage_idx == 3'd0) ? 8'd0 : used_ff) | (8'd1 << st_piv);
      st_row  = '0;
      st_n    = '0;
      st_done = 1'b0;
      ea      = '0;
      eb      = '0;
      c0      = '0;
      c1      = '0;
      if (cmd.stage_idx == 3'd0) begin
         st_row[0] = {st_piv, ra};
         st_row[1] = {st_piv, rb};
         st_row[2] = {st_piv, rc};
         st_n      = 3'd3;
      end else begin
         for (int e = 0; e < 6; e++) begin
            if (3'(e) < prev_cnt_ff) begin
               ea = prev_row_ff[e][5:3];
               eb = prev_row_ff[e][2:0];
               if (ea != st_piv && eb != st_piv) begin
                  if (st_n < 3'd6) begin
                     st_row[st_n] = {ea, eb};
                     st_n = st_n + 3'd1;
                  end
               end else if (!st_done) begin
                  st_done = 1'b1;
                  if (ra == ea || ra == eb) begin
                     c0 = rb;
                     c1 = rc;
                  end else if (rb == ea || rb == eb) begin
                     c0 = rc;
                     c1 = ra;
                  end else begin
                     c0 = ra;
                     c1 = rb;
                  end
                  if (!st_used[c0] && st_n < 3'd6) begin
                     st_row[st_n] = {st_piv, c0};
                     st_n = st_n + 3'd1;
                  end
                  if (!st_used[c1] && st_n < 3'd6) begin
                     st_row[st_n] = {st_piv, c1};
                     st_n = st_n + 3'd1;
                  end
               end
            end
         end
      end
   end

   always_comb begin
      depth_span = DW'(sd_ff[7] - sd_ff[0]);
      off_shift  = {off_ff, 15'd0};
      beyond_in  = (CMPW'(off_ff) > CMPW'(depth_span >> 15)) ||
                   (CMPW'(off_shift) >= CMPW'(depth_span));
      piv_in = '0;
      for (int k = 7; k >= 1; k--) begin
         if (depth_ff < sd_ff[k]) piv_in = 3'(k - 1);
      end
   end

   always_comb begin
      cur_edge = rows_ff[piv_ff][cmd.edge_idx];
      ext_cur  = ext_ff[cmd.axis];
      view_cur = view_ff[cmd.axis];
      da       = cd_ff[edge_a_ff];
      on_a     = corner_on(edge_a_ff, cmd.axis);
      on_b     = corner_on(edge_b_ff, cmd.axis);
      diff     = DW'(depth_ff - da);
      mag      = view_cur[VIEW_WIDTH-1] ? VIEW_WIDTH'(-view_cur) : VIEW_WIDTH'(view_cur);
      qc       = (div_q > DVW'(ext_cur)) ? ext_cur : div_q[EXW-1:0];
      if (status.need_interp)
         pos_val = COORD_WIDTH'(on_a ? ext_cur - qc : qc);
      else
         pos_val = on_a ? COORD_WIDTH'(ext_cur) : '0;
      if (ext_cur == '0)
         tex_val = '0;
      else if (div_q > DVW'(16'hffff))
         tex_val = 16'hffff;
      else
         tex_val = div_q[TEX_WIDTH-1:0];
      den = 17'((cnt_ff == '0) ? 13'd1 : cnt_ff) * 17'd10;
   end

   always_comb begin
      status.div_done    = div_done;
      status.beyond      = beyond_ff;
      status.need_interp = (on_a != on_b) && (ext_cur != '0) && (view_cur != '0) &&
                           (depth_ff > da);
      status.ext_zero    = (ext_cur == '0);
      status.edge_count  = ecnt_ff[piv_ff];
   end

   always_comb begin
      case (cmd.div_sel)
         DIV_OFF: begin
            div_dividend = DVW'(num_ff);
            div_divisor  = DIVISOR_WIDTH'(den);
         end
         DIV_POS: begin
            div_dividend = DVW'(diff);
            div_divisor  = DIVISOR_WIDTH'(mag);
         end
         DIV_TEX: begin
            div_dividend = DVW'({pos_ff[cmd.axis], 16'd0});
            div_divisor  = DIVISOR_WIDTH'(ext_cur);
         end
         default: begin
            div_dividend = '0;
            div_divisor  = '0;
         end
      endcase
   end

   vabs_divider #(
      .DVW(DVW),
      .DSW(DIVISOR_WIDTH)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_q),
      .done     (div_done)
   );

   always_ff @(posedge clock) begin
      if (cmd.accept) idx23_ff <= 19'(req_slice_index) * 19'd23;
      if (cmd.prod_en)
         prod_ff[cmd.axis] <= $signed(view_ff[cmd.axis]) * $signed({1'b0, ext_cur});
      if (cmd.depth_en) begin
         for (int k = 0; k < 8; k++) cd_ff[k] <= cd_in[k];
      end
      if (cmd.rank_en) begin
         for (int k = 0; k < 8; k++) begin
            sorted_ff[rk[k]] <= 3'(k);
            sd_ff[rk[k]]     <= cd_ff[k];
         end
      end
      if (cmd.stage_en) begin
         rows_ff[cmd.stage_idx] <= st_row;
         ecnt_ff[cmd.stage_idx] <= st_n;
         prev_row_ff <= st_row;
         prev_cnt_ff <= st_n;
         used_ff     <= st_used;
      end
      if (cmd.off_mul_en) num_ff <= OW'(idx23_ff) * OW'(ext_ff[0]);
      if (cmd.off_en) off_ff <= div_q[OW-1:0];
      if (cmd.check_en) begin
         beyond_ff <= beyond_in;
         depth_ff  <= sd_ff[0] + $signed(off_shift[DW-1:0]);
      end
      if (cmd.pivot_en) piv_ff <= piv_in;
      if (cmd.edge_en) begin
         edge_a_ff <= cur_edge[5:3];
         edge_b_ff <= cur_edge[2:0];
      end
      if (cmd.pos_en) pos_ff[cmd.axis] <= pos_val;
      if (cmd.tex_en) tex_ff[cmd.axis] <= tex_val;
      if (cmd.out_load) begin
         rsp_beyond_box  <= cmd.out_beyond;
         rsp_last_vertex <= cmd.out_last;
         rsp_pos_x <= cmd.out_beyond ? '0 : pos_ff[0];
         rsp_pos_y <= cmd.out_beyond ? '0 : pos_ff[1];
         rsp_pos_z <= cmd.out_beyond ? '0 : pos_ff[2];
         rsp_tex_u <= cmd.out_beyond ? '0 : tex_ff[0];
         rsp_tex_v <= cmd.out_beyond ? '0 : tex_ff[1];
         rsp_tex_w <= cmd.out_beyond ? '0 : tex_ff[2];
      end
   end
endmodule
`default_nettype wire

[rtl/vabs_controller.sv]
`default_nettype none
module vabs_controller (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [vabs_pkg::CSR_ADDR_WIDTH-1:0] csr_addr,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   input  wire vabs_pkg::status_type                status,
   output vabs_pkg::cmd_type                        cmd
);
   import vabs_pkg::*;

   state_type  state_ff, state_in;
   logic [1:0] axis_ff, axis_in;
   logic [2:0] stage_ff, stage_in;
   logic [2:0] edge_ff, edge_in;
   logic       valid_ff, valid_in;
   logic       last_ff, last_in;
   logic       last_edge;

   assign last_edge = ({1'b0, edge_ff} + 4'd1) == {1'b0, status.edge_count};

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      stage_in = stage_ff;
      edge_in  = edge_ff;
      last_in  = last_ff;
      valid_in = valid_ff && !(csr_we && csr_addr <= CSR_SLICE_COUNT);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               axis_in  = '0;
               stage_in = '0;
               state_in = valid_ff ? ST_OFFMUL : ST_PROD;
            end
         end
         ST_PROD: begin
            axis_in = axis_ff + 2'd1;
            if (axis_ff == 2'd2) begin
               axis_in  = '0;
               state_in = ST_DEPTH;
            end
         end
         ST_DEPTH: state_in = ST_RANK;
         ST_RANK:  state_in = ST_STAGE;
         ST_STAGE: begin
            stage_in = stage_ff + 3'd1;
            if (stage_ff == 3'd6) begin
               valid_in = 1'b1;
               state_in = ST_OFFMUL;
            end
         end
         ST_OFFMUL:  state_in = ST_OFFDIV;
         ST_OFFDIV:  state_in = ST_OFFWAIT;
         ST_OFFWAIT: if (status.div_done) state_in = ST_CHECK;
         ST_CHECK:   state_in = ST_PIVOT;
         ST_PIVOT: begin
            edge_in = '0;
            if (status.beyond) begin
               last_in  = 1'b1;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_EDGE;
            end
         end
         ST_EDGE: begin
            axis_in  = '0;
            state_in = (status.edge_count == '0) ? ST_IDLE : ST_POS;
         end
         ST_POS, ST_POSWAIT: begin
            if (state_ff == ST_POS && status.need_interp) begin
               state_in = ST_POSWAIT;
            end else if (state_ff == ST_POS || status.div_done) begin
               axis_in  = axis_ff + 2'd1;
               state_in = ST_POS;
               if (axis_ff == 2'd2) begin
                  axis_in  = '0;
                  state_in = ST_TEX;
               end
            end
         end
         ST_TEX, ST_TEXWAIT: begin
            if (state_ff == ST_TEX && !status.ext_zero) begin
               state_in = ST_TEXWAIT;
            end else if (state_ff == ST_TEX || status.div_done) begin
               axis_in  = axis_ff + 2'd1;
               state_in = ST_TEX;
               if (axis_ff == 2'd2) begin
                  axis_in  = '0;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            last_in  = last_edge;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               if (last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  edge_in  = edge_ff + 3'd1;
                  state_in = ST_EDGE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.div_sel   = DIV_OFF;
      cmd.axis      = axis_ff;
      cmd.stage_idx = stage_ff;
      cmd.edge_idx  = edge_ff;
      unique case (state_ff)
         ST_IDLE:    cmd.accept     = req_valid;
         ST_PROD:    cmd.prod_en    = 1'b1;
         ST_DEPTH:   cmd.depth_en   = 1'b1;
         ST_RANK:    cmd.rank_en    = 1'b1;
         ST_STAGE:   cmd.stage_en   = 1'b1;
         ST_OFFMUL:  cmd.off_mul_en = 1'b1;
         ST_OFFDIV:  cmd.div_start  = 1'b1;
         ST_OFFWAIT: cmd.off_en     = status.div_done;
         ST_CHECK:   cmd.check_en   = 1'b1;
         ST_PIVOT: begin
            cmd.pivot_en   = 1'b1;
            cmd.out_load   = status.beyond;
            cmd.out_beyond = status.beyond;
            cmd.out_last   = status.beyond;
         end
         ST_EDGE: cmd.edge_en = 1'b1;
         ST_POS: begin
            cmd.div_sel   = DIV_POS;
            cmd.div_start = status.need_interp;
            cmd.pos_en    = !status.need_interp;
         end
         ST_POSWAIT: begin
            cmd.div_sel = DIV_POS;
            cmd.pos_en  = status.div_done;
         end
         ST_TEX: begin
            cmd.div_sel   = DIV_TEX;
            cmd.div_start = !status.ext_zero;
            cmd.tex_en    = status.ext_zero;
         end
         ST_TEXWAIT: begin
            cmd.div_sel = DIV_TEX;
            cmd.tex_en  = status.div_done;
         end
         ST_LOAD: begin
            cmd.out_load = 1'b1;
            cmd.out_last = last_edge;
         end
         ST_EMIT: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         axis_ff  <= '0;
         stage_ff <= '0;
         edge_ff  <= '0;
         valid_ff <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         stage_ff <= stage_in;
         edge_ff  <= edge_in;
         valid_ff <= valid_in;
         last_ff  <= last_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);
endmodule
`default_nettype wire

[rtl/view_aligned_box_slicer.sv]
`default_nettype none
// View-aligned slicer: one slice index in, 3 to 6 polygon vertices out (or a single
// beyond_box transaction), one slice at a time. After any register write the first
// slice also rebuilds the corner sort and edge tables. Each slice then takes one
// offset divide, and each vertex up to one interpolation divide and three texture
// divides on a single bit-serial divider with a dividend of DVW = max(EXW+19,
// COORD_WIDTH+16) bits, with EXW = min(COORD_WIDTH, 24).
module view_aligned_box_slicer #(
   parameter int COORD_WIDTH = 24
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [vabs_pkg::CSR_ADDR_WIDTH-1:0] csr_addr,
   input  wire logic [vabs_pkg::CSR_DATA_WIDTH-1:0] csr_wdata,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [vabs_pkg::INDEX_WIDTH-1:0]    req_slice_index,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [COORD_WIDTH-1:0]                   rsp_pos_x,
   output logic [COORD_WIDTH-1:0]                   rsp_pos_y,
   output logic [COORD_WIDTH-1:0]                   rsp_pos_z,
   output logic [vabs_pkg::TEX_WIDTH-1:0]           rsp_tex_u,
   output logic [vabs_pkg::TEX_WIDTH-1:0]           rsp_tex_v,
   output logic [vabs_pkg::TEX_WIDTH-1:0]           rsp_tex_w,
   output logic                                     rsp_beyond_box,
   output logic                                     rsp_last_vertex
);
   import vabs_pkg::*;

   cmd_type    cmd;
   status_type status;

   vabs_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   vabs_datapath #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .req_slice_index (req_slice_index),
      .cmd             (cmd),
      .status          (status),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_pos_z       (rsp_pos_z),
      .rsp_tex_u       (rsp_tex_u),
      .rsp_tex_v       (rsp_tex_v),
      .rsp_tex_w       (rsp_tex_w),
      .rsp_beyond_box  (rsp_beyond_box),
      .rsp_last_vertex (rsp_last_vertex)
   );
endmodule
`default_nettype wire

[rtl/vabs_checker.sv]
`default_nettype none
module vabs_checker #(
   parameter int COORD_WIDTH = 24
) (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_ready,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire logic [COORD_WIDTH-1:0] rsp_pos_x,
   input wire logic [COORD_WIDTH-1:0] rsp_pos_y,
   input wire logic [COORD_WIDTH-1:0] rsp_pos_z,
   input wire logic                   rsp_beyond_box,
   input wire logic                   rsp_last_vertex
);
   a_one_slice: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("input taken while a vertex is pending");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid) else $error("result with no work done");

   a_beyond_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_beyond_box) |-> rsp_last_vertex) else $error("beyond not last");

   a_beyond_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_beyond_box) |->
         (rsp_pos_x == '0 && rsp_pos_y == '0 && rsp_pos_z == '0))
      else $error("beyond transaction carries a position");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_pos_x)))
      else $error("stalled transaction changed");
endmodule

bind view_aligned_box_slicer vabs_checker #(.COORD_WIDTH(COORD_WIDTH)) u_vabs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_pos_x       (rsp_pos_x),
   .rsp_pos_y       (rsp_pos_y),
   .rsp_pos_z       (rsp_pos_z),
   .rsp_beyond_box  (rsp_beyond_box),
   .rsp_last_vertex (rsp_last_vertex)
);
`default_nettype wire
